FILE: hw/rtl/ddpid_pkg.sv
// Shared package for the differential drive PID block.
// Holds the sequencer state type, register indexes, mode codes and angle constants.
// No dependencies.
`timescale 1ns / 1ps

package ddpid_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_GAIN_P      = 3'd0;
    localparam logic [2:0] REG_GAIN_I      = 3'd1;
    localparam logic [2:0] REG_GAIN_D      = 3'd2;
    localparam logic [2:0] REG_OUT_MIN     = 3'd3;
    localparam logic [2:0] REG_OUT_MAX     = 3'd4;
    localparam logic [2:0] REG_SUM_LIMIT   = 3'd5;
    localparam logic [2:0] REG_SAMPLE_PER  = 3'd6;
    localparam logic [2:0] REG_DEAD_BAND   = 3'd7;

    // Values of the action field
    localparam logic MODE_HEADING  = 1'b0;
    localparam logic MODE_DISTANCE = 1'b1;

    // Heading wrap limits in hundredths of a degree
    localparam logic signed [16:0] HALF_TURN = 17'sd18000;
    localparam logic signed [16:0] FULL_TURN = 17'sd36000;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_DIV_LOAD,
        ST_DIV,
        ST_ACC,
        ST_DRIVE
    } pid_state_t;

endpackage

FILE: hw/rtl/differential_drive_pid.sv
// Top level of the differential drive PID controller with anti-windup.
// One shared multiplier and a bit-serial divider under a small sequencer.
// Depends on ddpid_pkg.
`timescale 1ns / 1ps

// Usage:
// Input beats (action, target, measured, now_ms, base_drive) are taken on
// in_valid with in_stall low. in_stall is high while an item is being worked.
// An item issued earlier than sample_period_ms after the last update is
// dropped in the evaluation step and gives no output beat.
// An update runs the evaluation, multiply, divider load, accumulate and
// drive steps; when the elapsed time is nonzero, the derivative term also
// goes through a restoring divider that retires one quotient bit per
// cycle for a 32-bit quotient. The three products share one 16 x 21
// multiplier, one per cycle. One item is in flight at a time; the next is
// taken the cycle after the result lands in the output register.
// Output beats (drive_left, drive_right, error_value) sit in a register
// until taken; if out_stall holds a previous beat, the finished item waits
// in its last step and input stays stalled.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// belong in idle periods. Reset loads register defaults (out_min -32768,
// out_max 32767, others 0) and clears the integral, the previous error and
// the last update time.
module differential_drive_pid
    import ddpid_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration port
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [19:0]        cfg_data,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic signed [15:0] target,
    input  logic signed [15:0] measured,
    input  logic [31:0]        now_ms,
    input  logic signed [15:0] base_drive,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] drive_left,
    output logic signed [15:0] drive_right,
    output logic signed [16:0] error_value
);

    // configuration registers
    logic signed [15:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic signed [15:0] out_min_reg, out_max_reg;
    logic [19:0]        sum_limit_reg;
    logic [15:0]        sample_period_reg;
    logic [14:0]        dead_band_reg;

    // controller state
    pid_state_t         state_reg, state_next;
    logic signed [20:0] integral_reg, integral_next;
    logic signed [16:0] prev_err_reg, prev_err_next;
    logic [31:0]        last_time_reg, last_time_next;
    logic               out_valid_reg, out_valid_next;
    logic [4:0]         cnt_reg, cnt_next;

    // working registers
    logic               in_action_reg, in_action_next;
    logic signed [15:0] in_target_reg, in_target_next;
    logic signed [15:0] in_meas_reg, in_meas_next;
    logic [31:0]        in_now_reg, in_now_next;
    logic signed [15:0] in_base_reg, in_base_next;
    logic signed [16:0] err_reg, err_next;
    logic signed [20:0] sum_reg, sum_next;
    logic signed [17:0] de_reg, de_next;
    logic [31:0]        dt_reg, dt_next;
    logic signed [36:0] prod_reg, prod_next;
    logic signed [39:0] acc_reg, acc_next;
    logic [31:0]        div_q_reg, div_q_next;
    logic [31:0]        div_r_reg, div_r_next;
    logic               div_neg_reg, div_neg_next;
    logic signed [15:0] left_reg, left_next;
    logic signed [15:0] right_reg, right_next;
    logic signed [16:0] err_out_reg, err_out_next;

    // shared multiplier
    logic signed [15:0] mul_a;
    logic signed [20:0] mul_b;
    logic signed [36:0] mul_p;

    // evaluation step
    logic [31:0]        dt_now;
    logic               too_early;
    logic signed [16:0] e_raw, e_wrap;
    logic signed [21:0] sum_raw, lim_pos, lim_neg;

    // divider step
    logic [32:0]        rem_sh;
    logic [33:0]        rem_diff;
    logic [31:0]        prod_mag;

    // accumulate and drive step
    logic signed [32:0] quot_s;
    logic signed [31:0] corr;
    logic [16:0]        err_mag;
    logic               apply_corr;
    logic signed [33:0] left_raw, right_raw, corr_ext, min_ext, max_ext;

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign drive_left  = left_reg;
    assign drive_right = right_reg;
    assign error_value = err_out_reg;

    // multiplier operand select
    always_comb
    begin
        case (state_reg)
            ST_MUL_I:
            begin
                mul_a = gain_i_reg;
                mul_b = sum_reg;
            end
            ST_MUL_D:
            begin
                mul_a = gain_d_reg;
                mul_b = 21'(de_reg);
            end
            default:
            begin
                mul_a = gain_p_reg;
                mul_b = 21'(err_reg);
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // elapsed time, error, wrap, integral sum and its clamp limits
    always_comb
    begin
        dt_now    = in_now_reg - last_time_reg;
        too_early = dt_now < {16'd0, sample_period_reg};
        e_raw     = 17'(in_target_reg) - 17'(in_meas_reg);
        e_wrap    = e_raw;
        if (in_action_reg == MODE_HEADING)
        begin
            if (e_raw > HALF_TURN)
            begin
                e_wrap = e_raw - FULL_TURN;
            end
            else if (e_raw < -HALF_TURN)
            begin
                e_wrap = e_raw + FULL_TURN;
            end
        end
        sum_raw = 22'(integral_reg) + 22'(e_wrap);
        lim_pos = $signed({2'b00, sum_limit_reg});
        lim_neg = -lim_pos;
    end

    // divider step and magnitude of the derivative product
    always_comb
    begin
        rem_sh   = {div_r_reg, div_q_reg[31]};
        rem_diff = {1'b0, rem_sh} - {2'b00, dt_reg};
        prod_mag = prod_reg[36] ? 32'(-prod_reg) : prod_reg[31:0];
    end

    // correction and drive clamp
    always_comb
    begin
        quot_s     = div_neg_reg ? -$signed({1'b0, div_q_reg}) : $signed({1'b0, div_q_reg});
        corr       = acc_reg[39:8];
        err_mag    = err_reg[16] ? 17'(-err_reg) : 17'(err_reg);
        apply_corr = err_mag > {2'b00, dead_band_reg};
        corr_ext   = apply_corr ? 34'(corr) : 34'sd0;
        left_raw   = 34'(in_base_reg) + corr_ext;
        right_raw  = 34'(in_base_reg) - corr_ext;
        min_ext    = 34'(out_min_reg);
        max_ext    = 34'(out_max_reg);
        if (left_raw < min_ext)
        begin
            left_next = out_min_reg;
        end
        else if (left_raw > max_ext)
        begin
            left_next = out_max_reg;
        end
        else
        begin
            left_next = left_raw[15:0];
        end
        if (right_raw < min_ext)
        begin
            right_next = out_min_reg;
        end
        else if (right_raw > max_ext)
        begin
            right_next = out_max_reg;
        end
        else
        begin
            right_next = right_raw[15:0];
        end
    end

    // sequencer: next state and register updates
    always_comb
    begin
        state_next     = state_reg;
        integral_next  = integral_reg;
        prev_err_next  = prev_err_reg;
        last_time_next = last_time_reg;
        out_valid_next = out_valid_reg && out_stall;
        cnt_next       = cnt_reg;
        in_action_next = in_action_reg;
        in_target_next = in_target_reg;
        in_meas_next   = in_meas_reg;
        in_now_next    = in_now_reg;
        in_base_next   = in_base_reg;
        err_next       = err_reg;
        sum_next       = sum_reg;
        de_next        = de_reg;
        dt_next        = dt_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        div_q_next     = div_q_reg;
        div_r_next     = div_r_reg;
        div_neg_next   = div_neg_reg;
        err_out_next   = err_out_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    in_action_next = action;
                    in_target_next = target;
                    in_meas_next   = measured;
                    in_now_next    = now_ms;
                    in_base_next   = base_drive;
                    state_next     = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                err_next = e_wrap;
                de_next  = 18'(e_wrap) - 18'(prev_err_reg);
                dt_next  = dt_now;
                if (sum_raw < lim_neg)
                begin
                    sum_next = lim_neg[20:0];
                end
                else if (sum_raw > lim_pos)
                begin
                    sum_next = lim_pos[20:0];
                end
                else
                begin
                    sum_next = sum_raw[20:0];
                end
                state_next = too_early ? ST_IDLE : ST_MUL_P;
            end
            ST_MUL_P:
            begin
                prod_next  = mul_p;
                state_next = ST_MUL_I;
            end
            ST_MUL_I:
            begin
                acc_next   = 40'(prod_reg);
                prod_next  = mul_p;
                state_next = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                acc_next   = acc_reg + 40'(prod_reg);
                prod_next  = mul_p;
                state_next = ST_DIV_LOAD;
            end
            ST_DIV_LOAD:
            begin
                div_r_next = '0;
                cnt_next   = '1;
                if (dt_reg == 32'd0)
                begin
                    // zero elapsed time: no derivative term
                    div_q_next   = '0;
                    div_neg_next = 1'b0;
                    state_next   = ST_ACC;
                end
                else
                begin
                    div_q_next   = prod_mag;
                    div_neg_next = prod_reg[36];
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // one restoring step per cycle, quotient shifts in at the bottom
                if (!rem_diff[33])
                begin
                    div_r_next = rem_diff[31:0];
                end
                else
                begin
                    div_r_next = rem_sh[31:0];
                end
                div_q_next = {div_q_reg[30:0], ~rem_diff[33]};
                cnt_next   = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                acc_next   = acc_reg + 40'(quot_s);
                state_next = ST_DRIVE;
            end
            ST_DRIVE:
            begin
                // wait while a previous beat is still held by the receiver
                if (!(out_valid_reg && out_stall))
                begin
                    out_valid_next = 1'b1;
                    err_out_next   = err_reg;
                    integral_next  = sum_reg;
                    prev_err_next  = err_reg;
                    last_time_next = in_now_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            integral_reg      <= '0;
            prev_err_reg      <= '0;
            last_time_reg     <= '0;
            out_valid_reg     <= 1'b0;
            cnt_reg           <= '0;
            gain_p_reg        <= '0;
            gain_i_reg        <= '0;
            gain_d_reg        <= '0;
            out_min_reg       <= -16'sd32768;
            out_max_reg       <= 16'sd32767;
            sum_limit_reg     <= '0;
            sample_period_reg <= '0;
            dead_band_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            integral_reg  <= integral_next;
            prev_err_reg  <= prev_err_next;
            last_time_reg <= last_time_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_GAIN_P:     gain_p_reg        <= cfg_data[15:0];
                    REG_GAIN_I:     gain_i_reg        <= cfg_data[15:0];
                    REG_GAIN_D:     gain_d_reg        <= cfg_data[15:0];
                    REG_OUT_MIN:    out_min_reg       <= cfg_data[15:0];
                    REG_OUT_MAX:    out_max_reg       <= cfg_data[15:0];
                    REG_SUM_LIMIT:  sum_limit_reg     <= cfg_data;
                    REG_SAMPLE_PER: sample_period_reg <= cfg_data[15:0];
                    REG_DEAD_BAND:  dead_band_reg     <= cfg_data[14:0];
                    default:        ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        in_action_reg <= in_action_next;
        in_target_reg <= in_target_next;
        in_meas_reg   <= in_meas_next;
        in_now_reg    <= in_now_next;
        in_base_reg   <= in_base_next;
        err_reg       <= err_next;
        sum_reg       <= sum_next;
        de_reg        <= de_next;
        dt_reg        <= dt_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        div_q_reg     <= div_q_next;
        div_r_reg     <= div_r_next;
        div_neg_reg   <= div_neg_next;
        err_out_reg   <= err_out_next;
        if (state_reg == ST_DRIVE && !(out_valid_reg && out_stall))
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

endmodule
